// File: hw/rtl/accmw_pkg.sv
// Package for the accelerometer magnitude and motion window block.
// Holds field widths, window constants, the control word type and the microcode table.
// No dependencies.
package accmw_pkg;

  localparam int AXIS_W   = 16;
  localparam int ABS_W    = 14;
  localparam int SQ_W     = 28;
  localparam int MAG_W    = 14;
  localparam int REM_W    = 15;
  localparam int THR_W    = 14;
  localparam int TICK_W   = 6;
  localparam int PC_W     = 3;
  localparam int ITER_W   = 4;

  localparam logic [TICK_W-1:0] WINDOW_TICKS    = 6'd33;
  localparam logic [MAG_W-1:0]  ACTIVITY_LEVEL  = 14'd30;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 14'd150;
  localparam logic [ITER_W-1:0] SQRT_LAST_ITER  = 4'd13;

  // Jump conditions: when true the step counter loads the target, else it advances.
  typedef enum logic [1:0] {
    COND_NEVER     = 2'd0,
    COND_NO_INPUT  = 2'd1,
    COND_SQRT_BUSY = 2'd2,
    COND_OUT_BUSY  = 2'd3
  } cond_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic            take_in;
    axis_t           mul_sel;
    logic            acc_load;
    logic            acc_add;
    logic            sqrt_init;
    logic            sqrt_step;
    logic            diff_calc;
    logic            finish;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_SQ_X   = 3'd1;
  localparam logic [PC_W-1:0] PC_SQ_Y   = 3'd2;
  localparam logic [PC_W-1:0] PC_SQ_Z   = 3'd3;
  localparam logic [PC_W-1:0] PC_ROOT0  = 3'd4;
  localparam logic [PC_W-1:0] PC_ROOT   = 3'd5;
  localparam logic [PC_W-1:0] PC_DIFF   = 3'd6;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd7;

  // Microcode table, one control word per step; the last step wraps to the wait step.
  function automatic ctl_t rom_word(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '0;
    unique case (pc)
      PC_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = COND_NO_INPUT;
        w.target  = PC_WAIT;
      end
      PC_SQ_X: begin
        w.mul_sel  = AXIS_X;
        w.acc_load = 1'b1;
      end
      PC_SQ_Y: begin
        w.mul_sel = AXIS_Y;
        w.acc_add = 1'b1;
      end
      PC_SQ_Z: begin
        w.mul_sel = AXIS_Z;
        w.acc_add = 1'b1;
      end
      PC_ROOT0: begin
        w.sqrt_init = 1'b1;
      end
      PC_ROOT: begin
        w.sqrt_step = 1'b1;
        w.cond      = COND_SQRT_BUSY;
        w.target    = PC_ROOT;
      end
      PC_DIFF: begin
        w.diff_calc = 1'b1;
      end
      PC_FINISH: begin
        w.finish = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = PC_FINISH;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/accel_magnitude_motion_window.sv
// Top level of the accelerometer magnitude and motion window block.
// Microcoded sequencer over a squarer, accumulator and bit-serial square root.
// Depends on accmw_pkg.
//
// Requests: a new sample is taken only at the wait step, so each one runs through
//   every step, the square-root loop included, before the next is accepted; a
//   reading not yet taken stalls the finish step.
// Reset (rst, synchronous): step counter to the wait step, no result pending,
//   threshold 150, previous magnitude, tick count and motion latch cleared.
module accel_magnitude_motion_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [accmw_pkg::THR_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [accmw_pkg::AXIS_W-1:0] accel_x,
  input  logic signed [accmw_pkg::AXIS_W-1:0] accel_y,
  input  logic signed [accmw_pkg::AXIS_W-1:0] accel_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           activity_seen,
  output logic                           window_end,
  output logic                           motion_in_window,
  output logic [accmw_pkg::MAG_W-1:0]    magnitude
);

  accmw_pkg::ctl_t                 ctl;
  logic [accmw_pkg::PC_W-1:0]      pc;
  logic                            jump;
  logic                            out_busy;

  logic [accmw_pkg::THR_W-1:0]     motion_threshold;
  logic [accmw_pkg::ABS_W-1:0]     abs_x, abs_y, abs_z;
  logic [accmw_pkg::ABS_W-1:0]     abs_sel;
  logic [accmw_pkg::SQ_W-1:0]      square;
  logic [accmw_pkg::SQ_W-1:0]      acc;

  logic [accmw_pkg::SQ_W-1:0]      radicand;
  logic [accmw_pkg::REM_W-1:0]     rem;
  logic [accmw_pkg::MAG_W-1:0]     root;
  logic [accmw_pkg::ITER_W-1:0]    iter;
  logic [accmw_pkg::REM_W+1:0]     rem_shift;
  logic [accmw_pkg::REM_W+1:0]     trial;
  logic [accmw_pkg::REM_W+1:0]     rem_diff;

  logic [accmw_pkg::MAG_W-1:0]     previous_magnitude;
  logic [accmw_pkg::MAG_W-1:0]     diff;
  logic [accmw_pkg::TICK_W-1:0]    tick_count;
  logic [accmw_pkg::TICK_W-1:0]    tick_next;
  logic                            motion_latched;
  logic                            activity;
  logic                            motion;
  logic                            closing;
  logic                            finish_en;

  // Decode the current step
  assign ctl       = accmw_pkg::rom_word(pc);
  assign out_busy  = out_valid && !out_ready;
  assign in_ready  = ctl.take_in;
  assign cfg_ready = 1'b1;
  assign finish_en = ctl.finish && !out_busy;

  always_comb begin
    case (ctl.cond)
      accmw_pkg::COND_NO_INPUT:  jump = !in_valid;
      accmw_pkg::COND_SQRT_BUSY: jump = (iter != '0);
      accmw_pkg::COND_OUT_BUSY:  jump = out_busy;
      default:                   jump = 1'b0;
    endcase
  end

  // Advance the step counter, or jump
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= accmw_pkg::PC_WAIT;
    end else if (jump) begin
      pc <= ctl.target;
    end else begin
      pc <= pc + 1'b1;
    end
  end

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_threshold <= accmw_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      motion_threshold <= cfg_data;
    end
  end

  // Capture absolute values of the shifted axes
  function automatic logic [accmw_pkg::ABS_W-1:0] shifted_abs(
    input logic signed [accmw_pkg::AXIS_W-1:0] raw
  );
    logic [accmw_pkg::ABS_W-1:0] s;
    s = raw[accmw_pkg::AXIS_W-1:2];
    return s[accmw_pkg::ABS_W-1] ? (~s + 1'b1) : s;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.take_in && in_valid) begin
      abs_x <= shifted_abs(accel_x);
      abs_y <= shifted_abs(accel_y);
      abs_z <= shifted_abs(accel_z);
    end
  end

  // Square one axis per step and accumulate
  always_comb begin
    case (ctl.mul_sel)
      accmw_pkg::AXIS_Y: abs_sel = abs_y;
      accmw_pkg::AXIS_Z: abs_sel = abs_z;
      default:           abs_sel = abs_x;
    endcase
  end

  assign square = accmw_pkg::SQ_W'(abs_sel) * accmw_pkg::SQ_W'(abs_sel);

  always_ff @(posedge clk) begin
    if (ctl.acc_load) begin
      acc <= square;
    end else if (ctl.acc_add) begin
      acc <= acc + square;
    end
  end

  // Restoring square root, one result bit per step
  assign rem_shift = {rem, radicand[accmw_pkg::SQ_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign rem_diff  = rem_shift - trial;

  always_ff @(posedge clk) begin
    if (ctl.sqrt_init) begin
      radicand <= acc;
      rem      <= '0;
      root     <= '0;
      iter     <= accmw_pkg::SQRT_LAST_ITER;
    end else if (ctl.sqrt_step) begin
      radicand <= {radicand[accmw_pkg::SQ_W-3:0], 2'b00};
      iter     <= iter - 1'b1;
      if (rem_shift >= trial) begin
        rem  <= rem_diff[accmw_pkg::REM_W-1:0];
        root <= {root[accmw_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[accmw_pkg::REM_W-1:0];
        root <= {root[accmw_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  // Register the magnitude change against the previous sample
  always_ff @(posedge clk) begin
    if (ctl.diff_calc) begin
      diff <= (root >= previous_magnitude) ? (root - previous_magnitude)
                                           : (previous_magnitude - root);
    end
  end

  // Window bookkeeping
  assign activity  = (diff >= accmw_pkg::ACTIVITY_LEVEL);
  assign motion    = activity && (diff > motion_threshold);
  assign tick_next = tick_count + 1'b1;
  assign closing   = (tick_next == accmw_pkg::WINDOW_TICKS);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_magnitude <= '0;
      tick_count         <= '0;
      motion_latched     <= 1'b0;
    end else if (finish_en) begin
      previous_magnitude <= root;
      tick_count         <= closing ? '0 : tick_next;
      motion_latched     <= closing ? 1'b0 : (motion_latched || motion);
    end
  end

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_en) begin
      activity_seen    <= activity;
      window_end       <= closing;
      motion_in_window <= closing && (motion_latched || motion);
      magnitude        <= root;
    end
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> pc == accmw_pkg::PC_SQ_X)
    else $error("accepted request did not start the squaring steps");

  a_root_exits: assert property (@(posedge clk) disable iff (rst)
    pc == accmw_pkg::PC_ROOT && iter == '0 |=> pc == accmw_pkg::PC_DIFF)
    else $error("square root loop did not exit after its last iteration");

  a_tick_range: assert property (@(posedge clk) disable iff (rst)
    tick_count < accmw_pkg::WINDOW_TICKS)
    else $error("tick count reached the window length");

  a_window_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_end |-> tick_count == '0 && !motion_latched)
    else $error("window close did not clear tick count and latch");

  a_motion_needs_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_end |-> !motion_in_window)
    else $error("motion flag reported outside a window close");

endmodule

// File: verif/accel_magnitude_motion_window_tb.sv
// Self-checking testbench for accel_magnitude_motion_window.
// Drives sample and threshold requests, predicts each reading and checks every output.
// Depends on accmw_pkg and the accel_magnitude_motion_window RTL.
module accel_magnitude_motion_window_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_SAMPLES = 150;
  localparam int CFG_EVERY    = 50;

  typedef enum logic [1:0] {
    REQ_SAMPLE,
    REQ_THRESHOLD,
    REQ_DRAIN,
    REQ_RATES
  } req_kind_t;

  typedef struct {
    req_kind_t                          kind;
    logic signed [accmw_pkg::AXIS_W-1:0] x;
    logic signed [accmw_pkg::AXIS_W-1:0] y;
    logic signed [accmw_pkg::AXIS_W-1:0] z;
    logic [accmw_pkg::THR_W-1:0]         thr;
    int                                  send_pct;
    int                                  recv_pct;
  } request_t;

  typedef struct packed {
    logic                        activity;
    logic                        win_end;
    logic                        motion;
    logic [accmw_pkg::MAG_W-1:0] mag;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [accmw_pkg::THR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [accmw_pkg::AXIS_W-1:0] accel_x = '0;
  logic signed [accmw_pkg::AXIS_W-1:0] accel_y = '0;
  logic signed [accmw_pkg::AXIS_W-1:0] accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic activity_seen;
  logic window_end;
  logic motion_in_window;
  logic [accmw_pkg::MAG_W-1:0] magnitude;

  request_t pending_requests[$];
  reading_t expected_readings[$];

  // Handshakes seen at the last rising edge
  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Predictor state
  logic [accmw_pkg::MAG_W-1:0]  mag_prev;
  logic [accmw_pkg::TICK_W-1:0] ticks_in_window;
  logic                         motion_flag;
  logic [accmw_pkg::THR_W-1:0]  motion_thr;

  // Last queued sample, used to build slowly varying sequences
  logic signed [accmw_pkg::AXIS_W-1:0] last_x = '0;
  logic signed [accmw_pkg::AXIS_W-1:0] last_y = '0;
  logic signed [accmw_pkg::AXIS_W-1:0] last_z = '0;

  accel_magnitude_motion_window DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .accel_x          (accel_x),
    .accel_y          (accel_y),
    .accel_z          (accel_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .activity_seen    (activity_seen),
    .window_end       (window_end),
    .motion_in_window (motion_in_window),
    .magnitude        (magnitude)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
  end

  // Compute the reading for one sample and advance the window state
  function automatic reading_t predict_reading(
    input logic signed [accmw_pkg::AXIS_W-1:0] x,
    input logic signed [accmw_pkg::AXIS_W-1:0] y,
    input logic signed [accmw_pkg::AXIS_W-1:0] z
  );
    logic signed [accmw_pkg::AXIS_W-1:0] sx;
    logic signed [accmw_pkg::AXIS_W-1:0] sy;
    logic signed [accmw_pkg::AXIS_W-1:0] sz;
    longint sum_sq;
    longint root;
    longint trial;
    logic [accmw_pkg::MAG_W-1:0] mag;
    logic [accmw_pkg::MAG_W-1:0] diff;
    reading_t r;
    sx = x >>> 2;
    sy = y >>> 2;
    sz = z >>> 2;
    sum_sq = longint'(sx) * sx + longint'(sy) * sy + longint'(sz) * sz;
    // Build the floor root one bit at a time from the top
    root = 0;
    for (int b = accmw_pkg::MAG_W - 1; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    mag = root[accmw_pkg::MAG_W-1:0];
    diff = (mag >= mag_prev) ? mag - mag_prev : mag_prev - mag;
    r.activity = (diff >= accmw_pkg::ACTIVITY_LEVEL);
    if (r.activity && diff > motion_thr) motion_flag = 1'b1;
    ticks_in_window = ticks_in_window + 1'b1;
    r.win_end = (ticks_in_window == accmw_pkg::WINDOW_TICKS);
    r.motion = 1'b0;
    if (r.win_end) begin
      r.motion = motion_flag;
      motion_flag = 1'b0;
      ticks_in_window = '0;
    end
    mag_prev = mag;
    r.mag = mag;
    return r;
  endfunction

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
      mismatch_count++;
    end
  endtask

  // Monitor: check readings, track threshold writes, predict accepted samples
  always @(posedge clk) begin : reading_monitor
    reading_t exp_r;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      mag_prev = '0;
      ticks_in_window = '0;
      motion_flag = 1'b0;
      motion_thr = accmw_pkg::THRESHOLD_RESET;
      in_fire <= 1'b0;
      cfg_fire <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t ns: reading with none expected, magnitude %0d", $time, magnitude);
          mismatch_count++;
        end else begin
          exp_r = expected_readings.pop_front();
          check_field("activity_seen", exp_r.activity, activity_seen);
          check_field("window_end", exp_r.win_end, window_end);
          check_field("motion_in_window", exp_r.motion, motion_in_window);
          check_field("magnitude", exp_r.mag, magnitude);
        end
      end
      if (cfg_valid && cfg_ready) motion_thr = cfg_data;
      if (in_valid && in_ready) begin
        expected_readings.push_back(predict_reading(accel_x, accel_y, accel_z));
      end
      in_fire <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
    end
  end

  // Driver: present queued requests at the falling edge, hold each until taken
  always @(negedge clk) begin : request_driver
    request_t head;
    logic hold_in;
    logic hold_cfg;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      hold_in = in_valid && !in_fire;
      hold_cfg = cfg_valid && !cfg_fire;
      if (!hold_in && !hold_cfg && pending_requests.size() > 0) begin
        head = pending_requests[0];
        case (head.kind)
          REQ_SAMPLE: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              hold_in = 1'b1;
              accel_x <= head.x;
              accel_y <= head.y;
              accel_z <= head.z;
              void'(pending_requests.pop_front());
            end
          end
          REQ_THRESHOLD: begin
            // Write only once every reading is back
            if (expected_readings.size() == 0) begin
              hold_cfg = 1'b1;
              cfg_data <= head.thr;
              void'(pending_requests.pop_front());
            end
          end
          REQ_DRAIN: begin
            if (expected_readings.size() == 0) void'(pending_requests.pop_front());
          end
          REQ_RATES: begin
            send_idle_pct = head.send_pct;
            recv_idle_pct = head.recv_pct;
            void'(pending_requests.pop_front());
          end
        endcase
      end
      in_valid <= hold_in;
      cfg_valid <= hold_cfg;
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_sample(input logic signed [accmw_pkg::AXIS_W-1:0] x,
                             input logic signed [accmw_pkg::AXIS_W-1:0] y,
                             input logic signed [accmw_pkg::AXIS_W-1:0] z);
    request_t req;
    req = '{kind: REQ_SAMPLE, x: x, y: y, z: z, thr: '0, send_pct: 0, recv_pct: 0};
    pending_requests.push_back(req);
    last_x = x;
    last_y = y;
    last_z = z;
  endtask

  task automatic push_threshold(input logic [accmw_pkg::THR_W-1:0] thr);
    request_t req;
    req = '{kind: REQ_THRESHOLD, x: '0, y: '0, z: '0, thr: thr, send_pct: 0, recv_pct: 0};
    pending_requests.push_back(req);
  endtask

  task automatic push_drain();
    request_t req;
    req = '{kind: REQ_DRAIN, x: '0, y: '0, z: '0, thr: '0, send_pct: 0, recv_pct: 0};
    pending_requests.push_back(req);
  endtask

  task automatic push_rates(input int send_pct, input int recv_pct);
    request_t req;
    req = '{kind: REQ_RATES, x: '0, y: '0, z: '0, thr: '0,
            send_pct: send_pct, recv_pct: recv_pct};
    pending_requests.push_back(req);
  endtask

  function automatic logic signed [accmw_pkg::AXIS_W-1:0] nudge(
    input logic signed [accmw_pkg::AXIS_W-1:0] v,
    input int span
  );
    return v + accmw_pkg::AXIS_W'($urandom_range(2 * span)) - accmw_pkg::AXIS_W'(span);
  endfunction

  function automatic logic signed [accmw_pkg::AXIS_W-1:0] pick_extreme();
    case ($urandom_range(6))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return -16'sd1;
      4: return -16'sd4;
      5: return 16'sd3;
      default: return 16'sd4;
    endcase
  endfunction

  function automatic logic [accmw_pkg::THR_W-1:0] pick_threshold();
    case ($urandom_range(7))
      0: return '0;
      1: return accmw_pkg::THR_W'(29);
      2: return accmw_pkg::THR_W'(30);
      3: return accmw_pkg::THR_W'(31);
      4: return accmw_pkg::THRESHOLD_RESET;
      5: return '1;
      6: return accmw_pkg::THR_W'($urandom_range(64));
      default: return accmw_pkg::THR_W'($urandom_range(16383));
    endcase
  endfunction

  // Mix calm windows (small changes) with lively ones (jumps, extremes)
  task automatic add_random_phase(input int count, input int send_pct, input int recv_pct);
    int roll;
    bit calm;
    calm = 1'b0;
    push_rates(send_pct, recv_pct);
    for (int n = 0; n < count; n++) begin
      if (n % accmw_pkg::WINDOW_TICKS == 0) calm = ($urandom_range(2) == 0);
      if (n % CFG_EVERY == CFG_EVERY - 1) push_threshold(pick_threshold());
      if (n == count / 2) push_drain();
      roll = $urandom_range(99);
      if (calm) begin
        if (roll < 40) push_sample(last_x, last_y, last_z);
        else push_sample(nudge(last_x, 40), nudge(last_y, 40), nudge(last_z, 40));
      end else if (roll < 35) begin
        push_sample(nudge(last_x, 150), nudge(last_y, 150), nudge(last_z, 150));
      end else if (roll < 50) begin
        push_sample(last_x, last_y, last_z);
      end else if (roll < 85) begin
        push_sample(accmw_pkg::AXIS_W'($urandom()), accmw_pkg::AXIS_W'($urandom()),
                    accmw_pkg::AXIS_W'($urandom()));
      end else begin
        push_sample(pick_extreme(), pick_extreme(), pick_extreme());
      end
    end
  endtask

  initial begin
    push_rates(20, 81);
    // First sample after reset compares against zero, reset threshold
    push_sample(0, 0, 0);
    // Changes of 29, 30 and 31 with a zero threshold
    push_threshold('0);
    push_sample(116, 0, 0);
    push_sample(236, 0, 0);
    push_sample(360, 0, 0);
    // Threshold equal to the activity level: 30 is not enough, 31 is
    push_threshold(accmw_pkg::THR_W'(30));
    push_sample(480, 0, 0);
    push_sample(604, 0, 0);
    // Field extremes with motion disabled
    push_threshold('1);
    push_sample(-32768, -32768, -32768);
    push_sample(32767, 32767, 32767);
    push_sample(-1, -1, -1);
    push_sample(3, 3, 3);
    push_sample(-4, 0, 0);
    push_sample(0, 32767, 0);
    push_sample(0, 0, -32768);
    push_sample(-32768, 32767, 0);
    push_sample(16'h5555, 16'hAAAA, 16'h0F0F);
    push_sample(16'hF0F0, 16'h3333, 16'hCCCC);
    push_drain();
    push_threshold(accmw_pkg::THRESHOLD_RESET);

    add_random_phase(PHASE_SAMPLES, 20, 81);
    add_random_phase(PHASE_SAMPLES, 81, 20);
    add_random_phase(PHASE_SAMPLES, 0, 0);

    // Wait for all requests to go out and every reading to come back
    while (rst || pending_requests.size() != 0 || in_valid || cfg_valid ||
           expected_readings.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    // Flag readings that never came back
    if (expected_readings.size() != 0) begin
      $display("%0t ns: readings outstanding, expected %0d, actual %0d", $time, 0,
               expected_readings.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // End a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

endmodule
